[rtl/signed_int_to_decimal_ascii_core_defines.svh]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_defines.svh
// Assertion macros used by the sequencer of the signed integer to ASCII core.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Clocked implication check, disabled during reset
`define SITDA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Clocked next-cycle implication check, disabled during reset
`define SITDA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg
// Types, constants and helpers shared by the integer to ASCII core.
// ----------------------------------------------------------------------------
package sitda_pkg;

   // Default integer width
   localparam int VALUE_WIDTH_DEF = 32;

   // ASCII codes
   localparam logic [6:0] CHAR_ZERO  = 7'd48;
   localparam logic [6:0] CHAR_MINUS = 7'd45;

   // Output character width
   localparam int CHAR_WIDTH = 7;

   // Decimal digits needed for any value below 2**w: floor(w*log10(2)) + 1
   function automatic int num_digits(input int w);
      return ((w * 1233) >> 12) + 1;
   endfunction

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic conv_step;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic conv_done;
      logic negative;
      logic digit_last;
      logic out_free;
   } stat_type;

endpackage

[rtl/sitda_dpath.sv]
// ----------------------------------------------------------------------------
// sitda_dpath
// Magnitude, shift-and-add-3 binary to BCD register, digit emitter and
// output register.
// ----------------------------------------------------------------------------
module sitda_dpath
   import sitda_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [VALUE_WIDTH-1:0] value,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [CHAR_WIDTH-1:0]  rsp_char,
   output logic                   rsp_last
);

   localparam int NUM_DIGITS = num_digits(VALUE_WIDTH);
   localparam int BCD_WIDTH  = 4 * NUM_DIGITS;
   localparam int CONV_CNT_W = $clog2(VALUE_WIDTH);
   localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0]   bcd_adj;
   logic                   neg_ff, neg_in;
   logic                   started_ff, started_in;
   logic [CONV_CNT_W-1:0]  conv_cnt_ff, conv_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0] mag;
   logic [3:0]             top_digit;
   logic                   digit_last;
   logic                   skip;
   logic                   out_free;
   logic                   out_write;

   // Magnitude in unsigned arithmetic; most negative value wraps to 2**(W-1)
   assign mag = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;

   // Add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // Digit emitter: leading zeros are dropped, the units digit always goes out
   assign top_digit  = bcd_ff[BCD_WIDTH-1 -: 4];
   assign digit_last = (dig_cnt_ff == DIG_CNT_W'(NUM_DIGITS - 1));
   assign skip       = !started_ff && (top_digit == 4'd0) && !digit_last;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign out_write  = cmd.emit_sign || (cmd.emit_digit && !skip);

   // Next-state logic
   always_comb begin
      bin_in      = bin_ff;
      bcd_in      = bcd_ff;
      neg_in      = neg_ff;
      started_in  = started_ff;
      conv_cnt_in = conv_cnt_ff;
      dig_cnt_in  = dig_cnt_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;

      if (cmd.load) begin
         bin_in      = mag;
         bcd_in      = '0;
         neg_in      = value[VALUE_WIDTH-1];
         started_in  = 1'b0;
         conv_cnt_in = '0;
         dig_cnt_in  = '0;
      end

      if (cmd.conv_step) begin
         {bcd_in, bin_in} = {bcd_adj[BCD_WIDTH-2:0], bin_ff, 1'b0};
         conv_cnt_in      = conv_cnt_ff + CONV_CNT_W'(1);
      end

      if (cmd.emit_sign) begin
         rsp_char_in = CHAR_MINUS;
         rsp_last_in = 1'b0;
      end

      if (cmd.emit_digit) begin
         bcd_in     = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
         dig_cnt_in = dig_cnt_ff + DIG_CNT_W'(1);
         if (!skip) begin
            rsp_char_in = CHAR_ZERO + {3'd0, top_digit};
            rsp_last_in = digit_last;
            started_in  = 1'b1;
         end
      end

      if (out_write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         conv_cnt_ff  <= '0;
         dig_cnt_ff   <= '0;
         neg_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= started_in;
         conv_cnt_ff  <= conv_cnt_in;
         dig_cnt_ff   <= dig_cnt_in;
         neg_ff       <= neg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign stat.conv_done  = (conv_cnt_ff == CONV_CNT_W'(VALUE_WIDTH - 1));
   assign stat.negative   = neg_ff;
   assign stat.digit_last = digit_last;
   assign stat.out_free   = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char  = rsp_char_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

[rtl/sitda_ctrl.sv]
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: load, bit-serial conversion, sign if negative, then digit emission.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_core_defines.svh"

module sitda_ctrl
   import sitda_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SIGN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   // State transitions and commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (stat.conv_done) begin
               state_in = stat.negative ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (stat.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_digit = 1'b1;
               if (stat.digit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Checks
   `SITDA_ASSERT_NEXT(a_load_starts_conv, cmd.load, state_ff == ST_CONV,
      "load did not start conversion")
   `SITDA_ASSERT_NEXT(a_last_digit_idles, cmd.emit_digit && stat.digit_last,
      state_ff == ST_IDLE, "last digit did not return to idle")
   `SITDA_ASSERT_IMP(a_one_command, 1'b1,
      $onehot0({cmd.load, cmd.conv_step, cmd.emit_sign, cmd.emit_digit}),
      "more than one command at once")
   `SITDA_ASSERT_IMP(a_emit_needs_slot, cmd.emit_sign || cmd.emit_digit, stat.out_free,
      "character issued with output register full")

endmodule

[rtl/signed_int_to_decimal_ascii_core.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed two's complement integer to its decimal ASCII text,
// one character per output item, most significant first, sign leading.
//
//   Channel   Dir   Payload                          Handshake
//   req_*     in    tdata: value                     tvalid/tready
//   rsp_*     out   tdata: char_code, tlast: last    tvalid/tready
//
// NUM_DIGITS is floor(VALUE_WIDTH*log10(2)) + 1. The shift-and-add-3 BCD register
// takes one input bit per cycle, then the emitter scans one BCD digit per cycle
// while the output register is free, dropping leading zeros; a minus sign goes
// out before the digits of a negative value.
// Reset is synchronous and returns the sequencer to idle, output empty.
// rsp_tready low holds the emitter; the next item is taken while the last
// character still waits in the output register.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core
   import sitda_pkg::*;
#(
   parameter  int VALUE_WIDTH    = VALUE_WIDTH_DEF,
   localparam int REQ_DATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // [VALUE_WIDTH-1:0] value
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // [6:0] char_code
   output logic                      rsp_tlast
);

   cmd_type               cmd;
   stat_type              stat;
   logic [CHAR_WIDTH-1:0] rsp_char;

   // Sequencer
   sitda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Conversion datapath
   sitda_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .value     (req_tdata[VALUE_WIDTH-1:0]),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_char  (rsp_char),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_char};

endmodule

[verif/signed_int_to_decimal_ascii_core_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_checker
// Watches the request and response streams of the integer to ASCII core.
// Every accepted value is turned into its expected decimal text here, and
// each character that leaves the core is compared with the oldest one still
// waiting. Mismatch and leftover counts go back to the testbench top.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_checker
   import sitda_pkg::*;
#(
   parameter  int VALUE_WIDTH    = VALUE_WIDTH_DEF,
   localparam int REQ_DATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // [VALUE_WIDTH-1:0] value
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [7:0]                rsp_tdata,   // [6:0] char_code
   input  logic                      rsp_tlast,
   output int unsigned               error_count,
   output int unsigned               chars_pending
);

   // One character of expected text
   typedef struct packed {
      logic [CHAR_WIDTH-1:0] code;
      logic                  last;
   } text_char_type;

   text_char_type pending_chars [$];
   int unsigned   mismatches = 0;

   // Expected text of one value: optional sign, then digits MSD first
   function automatic void predict_text(input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [CHAR_WIDTH-1:0]  digits [0:19];
      int                     ndigits;
      text_char_type          item;
      // two's complement magnitude, exact for the most negative value
      magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      ndigits   = 0;
      do begin
         digits[ndigits] = CHAR_ZERO + CHAR_WIDTH'(magnitude % 10);
         ndigits++;
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (value[VALUE_WIDTH-1]) begin
         item.code = CHAR_MINUS;
         item.last = 1'b0;
         pending_chars.push_back(item);
      end
      for (int k = ndigits - 1; k >= 0; k--) begin
         item.code = digits[k];
         item.last = (k == 0);
         pending_chars.push_back(item);
      end
   endfunction

   // Compare outgoing characters, then queue text for new values
   always @(posedge clock) begin
      text_char_type exp_char;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_chars.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected char: tdata=%0d tlast=%0b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               exp_char = pending_chars.pop_front();
               if (rsp_tdata != {1'b0, exp_char.code} || rsp_tlast != exp_char.last) begin
                  mismatches++;
                  $display("%0t: mismatch: expected %0d/%0b, actual %0d/%0b",
                           $time, exp_char.code, exp_char.last, rsp_tdata, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_text(req_tdata[VALUE_WIDTH-1:0]);
      end
      error_count   <= mismatches;
      chars_pending <= pending_chars.size();
   end

endmodule

[verif/signed_int_to_decimal_ascii_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_tb
// Testbench top for the integer to ASCII core. Sends a directed set of
// edge values, then several hundred random ones in bursts with gaps, while
// the response side stalls on its own pattern, including long holds.
// A checker beside the core predicts and compares every character.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_tb;
   import sitda_pkg::*;

   localparam int VALUE_WIDTH    = VALUE_WIDTH_DEF;
   localparam int REQ_DATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int RANDOM_ITEMS   = 407;
   localparam int DRAIN_AT       = 200;
   localparam int TAIL_CYCLES    = 100;
   localparam int IDLE_LIMIT     = 5000;
   localparam int LONG_HOLD      = 400;

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;
   logic                      rsp_tlast;
   int unsigned               error_count;
   int unsigned               chars_pending;
   int unsigned               idle_cycles = 0;

   signed_int_to_decimal_ascii_core #(.VALUE_WIDTH(VALUE_WIDTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   signed_int_to_decimal_ascii_core_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .error_count   (error_count),
      .chars_pending (chars_pending)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offer one value and hold it until the core takes it
   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      req_tdata  <= REQ_DATA_WIDTH'(value);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Random value: full range, a chosen digit count, extremes or tiny
   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      longint lo;
      longint hi;
      longint mag;
      int     ndig;
      lo = 1;
      case ($urandom_range(0, 5))
         0, 1: return VALUE_WIDTH'($urandom);
         2, 3: begin
            ndig = $urandom_range(1, 10);
            repeat (ndig - 1) lo = lo * 10;
            hi = lo * 10 - 1;
            if (hi > 64'sd2147483648) hi = 64'sd2147483648;
            mag = lo + (longint'($urandom) % (hi - lo + 1));
            if ($urandom_range(0, 1) || mag == 64'sd2147483648)
               return VALUE_WIDTH'(-mag);
            return VALUE_WIDTH'(mag);
         end
         4: begin
            // near the top or bottom of the range
            if ($urandom_range(0, 1))
               return VALUE_WIDTH'(64'sd2147483647 - $urandom_range(0, 15));
            return VALUE_WIDTH'(-64'sd2147483648 + $urandom_range(0, 15));
         end
         default: return VALUE_WIDTH'($urandom_range(0, 40) - 20);
      endcase
   endfunction

   // Stimulus and verdict
   initial begin
      logic [VALUE_WIDTH-1:0] directed [$];
      int                     sent;
      int                     burst;
      int                     gap;
      directed = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
                   32'd100, -32'sd100, 32'd12345, -32'sd67890, 32'd999999999,
                   -32'sd999999999, 32'd1000000000, -32'sd1000000000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0000, 32'h8000_0001,
                   32'hAAAA_AAAA, 32'h5555_5555, 32'd4294967295};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed values back to back
      foreach (directed[i]) send_value(directed[i]);

      // Random values in bursts
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
            send_value(pick_value());
            sent++;
            if (sent == DRAIN_AT) begin
               // let every character come out before going on
               req_tvalid <= 1'b0;
               do @(posedge clock); while (chars_pending != 0);
            end
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      // Drain, then allow for stray output
      req_tvalid <= 1'b0;
      do @(posedge clock); while (chars_pending != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && chars_pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Response side stall pattern, with long holds now and then
   initial begin
      int seg;
      int mode;
      int len;
      seg = 0;
      forever begin
         if (seg == 4 || seg == 30) begin
            for (int i = 0; i < LONG_HOLD; i++) begin
               @(posedge clock);
               rsp_tready <= 1'b0;
            end
         end else begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 150);
            for (int i = 0; i < len; i++) begin
               @(posedge clock);
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= 1'($urandom_range(0, 1));
                  2:       rsp_tready <= ($urandom_range(0, 3) == 0);
                  default: rsp_tready <= ((i % 5) != 0);
               endcase
            end
         end
         seg++;
      end
   end

   // Watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule

[files.f]
+incdir+rtl
rtl/sitda_pkg.sv
rtl/sitda_dpath.sv
rtl/sitda_ctrl.sv
rtl/signed_int_to_decimal_ascii_core.sv
verif/signed_int_to_decimal_ascii_core_checker.sv
verif/signed_int_to_decimal_ascii_core_tb.sv
